/* src/bfgr_pkg.sv */
// Shared constants and sizes for the bitmap font glyph renderer.
package bfgr_pkg;

  // Glyph store geometry
  localparam int unsigned FontBytes = 4096;
  localparam int unsigned FontAw    = $clog2(FontBytes);

  // Glyph limits
  localparam int unsigned MaxGlyphWidth  = 8;
  localparam int unsigned MaxGlyphHeight = 32;
  localparam int unsigned RowAw          = $clog2(MaxGlyphHeight);

  // Bytes per framebuffer pixel, as a shift
  localparam int unsigned PixShift = 2;

  // Configuration register indexes
  localparam logic [2:0] CfgGlyphWidth   = 3'd0;
  localparam logic [2:0] CfgGlyphHeight  = 3'd1;
  localparam logic [2:0] CfgGlyphCount   = 3'd2;
  localparam logic [2:0] CfgBytesPerGlyph = 3'd3;
  localparam logic [2:0] CfgLinePitch    = 3'd4;

  // Commands
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDraw = 1'b1;

endpackage

/* src/bfgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bitmap_font_glyph_renderer.sv */
// Top level of the bitmap font glyph renderer: sequencer, shared multiplier, row output.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  command  | start_i, busy_o           | command_i, char_code_i, cell_x_i, cell_y_i,
//           |                           | fg_color_i, bg_color_i, font_index_i, font_byte_i
//  result   | res_valid_o (strobe)      | row_offset_o, pixel_count_o, pixel_0_o..7_o,
//           |                           | last_row_o
//  config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A load item is written into the glyph store at the accepting edge and leaves
// the block idle. A draw item steps through the shared 16x16 multiplier
// (cy*h, *pitch, cx*(w+1), glyph*bytes) and the first store read, then
// gives one row per cycle, h rows in all, h = glyph height. A draw with
// zero height is not started and the block stays idle. Reset loads the register
// defaults; the glyph store is not cleared. The receiver cannot stall results.
module bitmap_font_glyph_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [15:0] char_code_i,
  input  logic [9:0]  cell_x_i,
  input  logic [9:0]  cell_y_i,
  input  logic [31:0] fg_color_i,
  input  logic [31:0] bg_color_i,
  input  logic [11:0] font_index_i,
  input  logic [7:0]  font_byte_i,
  // result channel
  output logic        res_valid_o,
  output logic [31:0] row_offset_o,
  output logic [3:0]  pixel_count_o,
  output logic [31:0] pixel_0_o,
  output logic [31:0] pixel_1_o,
  output logic [31:0] pixel_2_o,
  output logic [31:0] pixel_3_o,
  output logic [31:0] pixel_4_o,
  output logic [31:0] pixel_5_o,
  output logic [31:0] pixel_6_o,
  output logic [31:0] pixel_7_o,
  output logic        last_row_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned Aw = bfgr_pkg::FontAw;
  localparam int unsigned Rw = bfgr_pkg::RowAw;
  localparam int unsigned Np = bfgr_pkg::MaxGlyphWidth;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMulYh = 3'd1;
  localparam logic [2:0] StMulP  = 3'd2;
  localparam logic [2:0] StMulX  = 3'd3;
  localparam logic [2:0] StMulG  = 3'd4;
  localparam logic [2:0] StFetch = 3'd5;
  localparam logic [2:0] StRow   = 3'd6;

  logic [2:0]  state_q, state_d;

  // Configuration registers
  logic [3:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [9:0]  glyph_count_q;
  logic [5:0]  bytes_per_glyph_q;
  logic [15:0] line_pitch_q;

  // Draw context
  logic [9:0]  cx_q, cy_q;
  logic [31:0] fg_q, bg_q;
  logic        zero_q;
  logic [9:0]  glyph_q;
  logic [3:0]  w_q;
  logic [5:0]  h_q;
  logic [15:0] t_q;
  logic [31:0] off_q;
  logic [Aw-1:0] rd_addr_q;
  logic [Rw-1:0] row_q;

  // Result registers
  logic        res_valid_q;
  logic [31:0] row_offset_q;
  logic [3:0]  pixel_count_q;
  logic [31:0] pixel_q [Np];
  logic        last_row_q;

  logic        accept;
  logic        draw_go;
  logic [3:0]  w_sat;
  logic [5:0]  h_sat;
  logic [9:0]  glyph_sel;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic        ram_we, ram_re;
  logic [7:0]  row_bits;
  logic [31:0] pixel_d [Np];
  logic        last_d;

  assign accept      = start_i && (state_q == StIdle);
  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Saturate geometry and pick the glyph
  assign w_sat = (glyph_width_q > 4'(Np)) ? 4'(Np) : glyph_width_q;
  assign h_sat = (glyph_height_q > 6'(bfgr_pkg::MaxGlyphHeight))
               ? 6'(bfgr_pkg::MaxGlyphHeight) : glyph_height_q;
  assign glyph_sel = ((char_code_i != 16'd0) && (char_code_i < {6'd0, glyph_count_q}))
                   ? char_code_i[9:0] : 10'd0;
  assign draw_go = accept && (command_i == bfgr_pkg::CmdDraw) && (h_sat != 6'd0);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q     <= 4'd8;
      glyph_height_q    <= 6'd16;
      glyph_count_q     <= 10'd256;
      bytes_per_glyph_q <= 6'd16;
      line_pitch_q      <= 16'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bfgr_pkg::CfgGlyphWidth:    glyph_width_q     <= cfg_data_i[3:0];
        bfgr_pkg::CfgGlyphHeight:   glyph_height_q    <= cfg_data_i[5:0];
        bfgr_pkg::CfgGlyphCount:    glyph_count_q     <= cfg_data_i[9:0];
        bfgr_pkg::CfgBytesPerGlyph: bytes_per_glyph_q <= cfg_data_i[5:0];
        bfgr_pkg::CfgLinePitch:     line_pitch_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulYh: begin
        mul_a = {6'd0, cy_q};
        mul_b = {10'd0, h_q};
      end
      StMulP: begin
        mul_a = t_q;
        mul_b = line_pitch_q;
      end
      StMulX: begin
        mul_a = {6'd0, cx_q};
        mul_b = {12'd0, w_q + 4'd1};
      end
      StMulG: begin
        mul_a = {6'd0, glyph_q};
        mul_b = {10'd0, bytes_per_glyph_q};
      end
      default: ;
    endcase
  end

  assign mul_p = 32'(mul_a) * 32'(mul_b);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (draw_go) state_d = StMulYh;
      StMulYh: state_d = StMulP;
      StMulP:  state_d = StMulX;
      StMulX:  state_d = StMulG;
      StMulG:  state_d = StFetch;
      StFetch: state_d = StRow;
      StRow:   if (last_d) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the draw item and run the offset and address arithmetic
  always_ff @(posedge clk_i) begin
    if (draw_go) begin
      cx_q    <= cell_x_i;
      cy_q    <= cell_y_i;
      fg_q    <= fg_color_i;
      bg_q    <= bg_color_i;
      zero_q  <= (char_code_i == 16'd0);
      glyph_q <= glyph_sel;
      w_q     <= w_sat;
      h_q     <= h_sat;
    end
    case (state_q)
      StMulYh: t_q <= mul_p[15:0];
      StMulP:  off_q <= mul_p;
      StMulX:  off_q <= off_q + {mul_p[31-bfgr_pkg::PixShift:0], bfgr_pkg::PixShift'(0)};
      StMulG:  rd_addr_q <= mul_p[Aw-1:0];
      StFetch: rd_addr_q <= rd_addr_q + Aw'(1);
      StRow: begin
        rd_addr_q <= rd_addr_q + Aw'(1);
        off_q     <= off_q + {16'd0, line_pitch_q};
      end
      default: ;
    endcase
  end

  // Row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (state_q == StFetch) begin
      row_q <= '0;
    end else if (state_q == StRow) begin
      row_q <= row_q + Rw'(1);
    end
  end

  assign last_d = ((6'(row_q) + 6'd1) == h_q);

  // Glyph store
  assign ram_we = accept && (command_i == bfgr_pkg::CmdLoad);
  assign ram_re = (state_q == StFetch) || (state_q == StRow);

  bfgr_ram #(
    .Width (8),
    .Depth (bfgr_pkg::FontBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (font_index_i[Aw-1:0]),
    .wdata_i (font_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (row_bits)
  );

  // Expand the row byte into pixel colors, MSB first from bit w-1
  always_comb begin
    logic [3:0] bit_idx;
    for (int k = 0; k < Np; k++) begin
      bit_idx    = w_q - 4'd1 - 4'(k);
      pixel_d[k] = '0;
      if (4'(k) < w_q) begin
        pixel_d[k] = (!zero_q && row_bits[bit_idx[2:0]]) ? fg_q : bg_q;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == StRow);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == StRow) begin
      row_offset_q  <= off_q;
      pixel_count_q <= w_q;
      last_row_q    <= last_d;
      for (int k = 0; k < Np; k++) begin
        pixel_q[k] <= pixel_d[k];
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign row_offset_o  = row_offset_q;
  assign pixel_count_o = pixel_count_q;
  assign pixel_0_o     = pixel_q[0];
  assign pixel_1_o     = pixel_q[1];
  assign pixel_2_o     = pixel_q[2];
  assign pixel_3_o     = pixel_q[3];
  assign pixel_4_o     = pixel_q[4];
  assign pixel_5_o     = pixel_q[5];
  assign pixel_6_o     = pixel_q[6];
  assign pixel_7_o     = pixel_q[7];
  assign last_row_o    = last_row_q;

endmodule
